// ----- src/qtc_pkg.sv -----
// ----------------------------------------------------------------------------
// qtc_pkg
// Shared codes and control types of the quadtree tile id codec.
// ----------------------------------------------------------------------------
package qtc_pkg;

  // Opcodes carried on the slave tuser
  localparam logic [1:0] OP_ENCODE = 2'd0;
  localparam logic [1:0] OP_DECODE = 2'd1;
  localparam logic [1:0] OP_LEVELS = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_MIN_X = 2'd0;
  localparam logic [1:0] REG_MIN_Y = 2'd1;
  localparam logic [1:0] REG_MAX_X = 2'd2;
  localparam logic [1:0] REG_MAX_Y = 2'd3;

  localparam int CFG_W = 16;

  // Quadrant numbers: right/left of the centre column, top/bottom of the centre row
  localparam logic [1:0] QUAD_RT = 2'd0;
  localparam logic [1:0] QUAD_LT = 2'd1;
  localparam logic [1:0] QUAD_LB = 2'd2;
  localparam logic [1:0] QUAD_RB = 2'd3;

  // One level stage for each level up to the largest 4-bit level count
  localparam int LEVEL_STEPS = 15;
  localparam logic [3:0] LEVELS_NONE = 4'hF;

  typedef struct packed {
    logic [1:0] opcode;
    logic       bad;     // encode too deep, or decode with leftover bits
    logic       found;   // needed-levels search has hit
    logic [3:0] lvl;     // level of the hit
  } ctrl_t;

endpackage

// ----- src/quadtree_tile_id_codec_unit.sv -----
// ----------------------------------------------------------------------------
// quadtree_tile_id_codec_unit
// Quadtree tile id encode, decode and needed-levels search over a
// configured root box, as a stream pipeline.
// ----------------------------------------------------------------------------
// The unit takes one item per clock while the master side keeps up, and gives
// one result per item, in order. The item passes one capture register, loaded
// at the accepting edge, then fifteen level stages (one quadtree level each,
// the most a 4-bit level count can name) and the output register. Each level
// stage holds a centre add per axis, the quadrant compares and one area
// multiply, so the level pipeline sets the latency and the unit sustains one
// item per cycle while the master side keeps up. Every stage stalls only when
// the one after it is full, so bubbles close up and an item is taken while a
// finished result waits on the master side. The opcode travels on s_tuser; ok
// comes back on m_tuser. Write the root box registers only while the pipeline
// is empty.
module quadtree_tile_id_codec_unit import qtc_pkg::*; #(
  parameter int COORD_WIDTH = 16,
  parameter int MAX_LEVELS  = 12
) (
  input  logic               clk,
  input  logic               rst,
  // Configuration write port
  input  logic               cfg_wr_en,
  input  logic [1:0]         cfg_index,
  input  logic [CFG_W-1:0]   cfg_wdata,
  // Slave side
  input  logic               s_tvalid,
  output logic               s_tready,
  // loc_x[15:0], loc_y[31:16], depth_req[35:32], tile_id[67:36],
  // max_size[99:68], zero fill [103:100]
  input  logic [103:0]       s_tdata,
  // opcode[1:0]
  input  logic [1:0]         s_tuser,
  // Master side
  output logic               m_tvalid,
  input  logic               m_tready,
  // result_id[31:0], out_min_x[47:32], out_min_y[63:48], out_max_x[79:64],
  // out_max_y[95:80], levels_out[99:96], zero fill [103:100]
  output logic [103:0]       m_tdata,
  // ok[0]
  output logic               m_tuser
);

  localparam int CW   = COORD_WIDTH;
  localparam int PW   = 2*CW + 2;
  localparam int CMPW = (PW > 32) ? PW : 32;
  localparam int LAST = LEVEL_STEPS;

  // Root box registers
  logic [CFG_W-1:0] root_min_x, root_min_y, root_max_x, root_max_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      root_min_x <= '0;
      root_min_y <= '0;
      root_max_x <= '1;
      root_max_y <= '1;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_MIN_X: root_min_x <= cfg_wdata;
        REG_MIN_Y: root_min_y <= cfg_wdata;
        REG_MAX_X: root_max_x <= cfg_wdata;
        REG_MAX_Y: root_max_y <= cfg_wdata;
        default:   root_min_x <= root_min_x;
      endcase
    end
  end

  // Input field unpack
  logic [1:0]  in_opcode;
  logic [15:0] in_loc_x, in_loc_y;
  logic [3:0]  in_depth;
  logic [31:0] in_tile_id, in_max_size;

  assign in_opcode   = s_tuser;
  assign in_loc_x    = s_tdata[15:0];
  assign in_loc_y    = s_tdata[31:16];
  assign in_depth    = s_tdata[35:32];
  assign in_tile_id  = s_tdata[67:36];
  assign in_max_size = s_tdata[99:68];

  // Pipeline stage arrays: index 0 is the capture register,
  // index k+1 the output of level stage k
  logic                 st_valid [0:LAST];
  ctrl_t                st_ctrl  [0:LAST];
  logic [CW-1:0]        st_min_x [0:LAST];
  logic [CW-1:0]        st_min_y [0:LAST];
  logic [CW-1:0]        st_max_x [0:LAST];
  logic [CW-1:0]        st_max_y [0:LAST];
  logic [CW-1:0]        st_x     [0:LAST];
  logic [CW-1:0]        st_y     [0:LAST];
  logic [31:0]          st_code  [0:LAST];
  logic [31:0]          st_limit [0:LAST];
  logic [CW:0]          st_w     [0:LAST];
  logic [CW:0]          st_h     [0:LAST];
  logic [PW-1:0]        st_prod  [0:LAST];

  // Load enables: a stage loads when empty or when the next one loads
  logic [LAST+1:0] ld;
  logic            out_valid;

  assign ld[LAST+1] = !out_valid || m_tready;

  genvar g;
  generate
    for (g = 0; g <= LAST; g++) begin : g_ld
      assign ld[g] = !st_valid[g] || ld[g+1];
    end
  endgenerate

  assign s_tready = ld[0];

  // Capture stage: root box, spans, id preparation
  logic [CW-1:0] c_min_x, c_min_y, c_max_x, c_max_y;
  logic [27:0]   id_rest;
  logic          leftover, too_deep;
  ctrl_t         cap_ctrl;

  assign c_min_x = CW'(root_min_x);
  assign c_min_y = CW'(root_min_y);
  assign c_max_x = CW'(root_max_x);
  assign c_max_y = CW'(root_max_y);

  // Bits left above the quadrant pairs that the level count uses
  assign id_rest  = in_tile_id[31:4] >> {in_tile_id[3:0], 1'b0};
  assign leftover = (id_rest != '0);
  assign too_deep = (in_depth > 4'(MAX_LEVELS));

  always_comb begin
    cap_ctrl.opcode = in_opcode;
    cap_ctrl.found  = 1'b0;
    cap_ctrl.lvl    = '0;
    case (in_opcode)
      OP_ENCODE: cap_ctrl.bad = too_deep;
      OP_DECODE: cap_ctrl.bad = leftover;
      default:   cap_ctrl.bad = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid[0] <= 1'b0;
    end else if (ld[0]) begin
      st_valid[0] <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      st_ctrl[0]  <= cap_ctrl;
      st_min_x[0] <= c_min_x;
      st_min_y[0] <= c_min_y;
      st_max_x[0] <= c_max_x;
      st_max_y[0] <= c_max_y;
      st_x[0]     <= CW'(in_loc_x);
      st_y[0]     <= CW'(in_loc_y);
      // Level count in the low nibble either way; decode keeps its pairs
      st_code[0]  <= (in_opcode == OP_DECODE) ? in_tile_id : {28'd0, in_depth};
      st_limit[0] <= in_max_size;
      st_w[0]     <= {1'b0, c_max_x} - {1'b0, c_min_x} + (CW+1)'(1);
      st_h[0]     <= {1'b0, c_max_y} - {1'b0, c_min_y} + (CW+1)'(1);
      st_prod[0]  <= '0;
    end
  end

  // Level stages
  generate
    for (g = 0; g < LAST; g++) begin : g_lvl
      qtc_stage #(
        .COORD_WIDTH (CW),
        .MAX_LEVELS  (MAX_LEVELS),
        .LEVEL       (g)
      ) u_stage (
        .clk       (clk),
        .rst       (rst),
        .load      (ld[g+1]),
        .in_valid  (st_valid[g]),
        .in_ctrl   (st_ctrl[g]),
        .in_min_x  (st_min_x[g]),
        .in_min_y  (st_min_y[g]),
        .in_max_x  (st_max_x[g]),
        .in_max_y  (st_max_y[g]),
        .in_x      (st_x[g]),
        .in_y      (st_y[g]),
        .in_code   (st_code[g]),
        .in_limit  (st_limit[g]),
        .in_w      (st_w[g]),
        .in_h      (st_h[g]),
        .in_prod   (st_prod[g]),
        .out_valid (st_valid[g+1]),
        .out_ctrl  (st_ctrl[g+1]),
        .out_min_x (st_min_x[g+1]),
        .out_min_y (st_min_y[g+1]),
        .out_max_x (st_max_x[g+1]),
        .out_max_y (st_max_y[g+1]),
        .out_x     (st_x[g+1]),
        .out_y     (st_y[g+1]),
        .out_code  (st_code[g+1]),
        .out_limit (st_limit[g+1]),
        .out_w     (st_w[g+1]),
        .out_h     (st_h[g+1]),
        .out_prod  (st_prod[g+1])
      );
    end
  endgenerate

  // Output stage: last area compare, then select fields by opcode
  ctrl_t       fin_ctrl;
  logic [31:0] res_id_next;
  logic [15:0] o_min_x_next, o_min_y_next, o_max_x_next, o_max_y_next;
  logic [3:0]  levels_next;
  logic        ok_next;

  always_comb begin
    fin_ctrl = st_ctrl[LAST];
    if ((LAST - 1 <= MAX_LEVELS) && (fin_ctrl.opcode == OP_LEVELS) && !fin_ctrl.found &&
        (CMPW'(st_prod[LAST]) <= CMPW'(st_limit[LAST]))) begin
      fin_ctrl.found = 1'b1;
      fin_ctrl.lvl   = 4'(LAST - 1);
    end
  end

  always_comb begin
    res_id_next  = '0;
    o_min_x_next = '0;
    o_min_y_next = '0;
    o_max_x_next = '0;
    o_max_y_next = '0;
    levels_next  = '0;
    ok_next      = 1'b0;
    case (fin_ctrl.opcode)
      OP_ENCODE: begin
        res_id_next = fin_ctrl.bad ? 32'd0 : st_code[LAST];
        ok_next     = !fin_ctrl.bad;
      end
      OP_DECODE: begin
        o_min_x_next = 16'(st_min_x[LAST]);
        o_min_y_next = 16'(st_min_y[LAST]);
        o_max_x_next = 16'(st_max_x[LAST]);
        o_max_y_next = 16'(st_max_y[LAST]);
        levels_next  = st_code[LAST][3:0];
        ok_next      = !fin_ctrl.bad;
      end
      OP_LEVELS: begin
        levels_next = fin_ctrl.found ? fin_ctrl.lvl : LEVELS_NONE;
        ok_next     = fin_ctrl.found;
      end
      default: begin
        ok_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ld[LAST+1]) begin
      out_valid <= st_valid[LAST];
    end
  end

  always_ff @(posedge clk) begin
    if (ld[LAST+1]) begin
      m_tdata <= {4'd0, levels_next, o_max_y_next, o_max_x_next,
                  o_min_y_next, o_min_x_next, res_id_next};
      m_tuser <= ok_next;
    end
  end

  assign m_tvalid = out_valid;

endmodule

// ----- src/qtc_stage.sv -----
// ----------------------------------------------------------------------------
// qtc_stage
// One registered quadtree level: split the box at its centre, pick and
// descend a quadrant, and form one area term of the needed-levels search.
// ----------------------------------------------------------------------------
module qtc_stage import qtc_pkg::*; #(
  parameter int COORD_WIDTH = 16,
  parameter int MAX_LEVELS  = 12,
  parameter int LEVEL       = 0
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       load,
  input  logic                       in_valid,
  input  ctrl_t                      in_ctrl,
  input  logic [COORD_WIDTH-1:0]     in_min_x,
  input  logic [COORD_WIDTH-1:0]     in_min_y,
  input  logic [COORD_WIDTH-1:0]     in_max_x,
  input  logic [COORD_WIDTH-1:0]     in_max_y,
  input  logic [COORD_WIDTH-1:0]     in_x,
  input  logic [COORD_WIDTH-1:0]     in_y,
  input  logic [31:0]                in_code,
  input  logic [31:0]                in_limit,
  input  logic [COORD_WIDTH:0]       in_w,
  input  logic [COORD_WIDTH:0]       in_h,
  input  logic [2*COORD_WIDTH+1:0]   in_prod,
  output logic                       out_valid,
  output ctrl_t                      out_ctrl,
  output logic [COORD_WIDTH-1:0]     out_min_x,
  output logic [COORD_WIDTH-1:0]     out_min_y,
  output logic [COORD_WIDTH-1:0]     out_max_x,
  output logic [COORD_WIDTH-1:0]     out_max_y,
  output logic [COORD_WIDTH-1:0]     out_x,
  output logic [COORD_WIDTH-1:0]     out_y,
  output logic [31:0]                out_code,
  output logic [31:0]                out_limit,
  output logic [COORD_WIDTH:0]       out_w,
  output logic [COORD_WIDTH:0]       out_h,
  output logic [2*COORD_WIDTH+1:0]   out_prod
);

  localparam int PW        = 2*COORD_WIDTH + 2;
  localparam int CMPW      = (PW > 32) ? PW : 32;
  localparam bit DO_CMP    = (LEVEL >= 1) && (LEVEL - 1 <= MAX_LEVELS);
  localparam int CMP_LEVEL = (LEVEL > 0) ? LEVEL - 1 : 0;

  logic [COORD_WIDTH:0]   span_x, span_y;
  logic [COORD_WIDTH-1:0] cx, cy;
  logic [1:0]             q_enc, q_id, q;
  logic                   active, enc_active;
  logic [31:0]            code_next;
  logic [COORD_WIDTH-1:0] min_x_next, min_y_next, max_x_next, max_y_next;
  ctrl_t                  ctrl_next;

  assign span_x = {1'b0, in_max_x} - {1'b0, in_min_x} + (COORD_WIDTH+1)'(1);
  assign span_y = {1'b0, in_max_y} - {1'b0, in_min_y} + (COORD_WIDTH+1)'(1);
  assign cx     = in_min_x + span_x[COORD_WIDTH:1];
  assign cy     = in_min_y + span_y[COORD_WIDTH:1];

  always_comb begin
    if (in_y <= cy) begin
      q_enc = (in_x >= cx) ? QUAD_RT : QUAD_LT;
    end else begin
      q_enc = (in_x < cx) ? QUAD_LB : QUAD_RB;
    end
  end

  // Level count sits in code[3:0] for both encode and decode
  assign active = (((in_ctrl.opcode == OP_ENCODE) && !in_ctrl.bad) ||
                   (in_ctrl.opcode == OP_DECODE)) && (in_code[3:0] > 4'(LEVEL));
  assign enc_active = active && (in_ctrl.opcode == OP_ENCODE);

  generate
    if (2*LEVEL + 5 <= 31) begin : g_pair
      assign q_id = in_code[2*LEVEL+5 -: 2];
      always_comb begin
        code_next = in_code;
        if (enc_active) begin
          code_next[2*LEVEL+5 -: 2] = q_enc;
        end
      end
    end else begin : g_nopair
      // Beyond the pairs an id can carry: read as the first quadrant
      assign q_id      = QUAD_RT;
      assign code_next = in_code;
    end
  endgenerate

  assign q = (in_ctrl.opcode == OP_ENCODE) ? q_enc : q_id;

  always_comb begin
    min_x_next = in_min_x;
    min_y_next = in_min_y;
    max_x_next = in_max_x;
    max_y_next = in_max_y;
    if (active) begin
      case (q)
        QUAD_RT: begin
          min_x_next = cx;
          max_y_next = cy;
        end
        QUAD_LT: begin
          max_x_next = cx;
          max_y_next = cy;
        end
        QUAD_LB: begin
          max_x_next = cx;
          min_y_next = cy;
        end
        default: begin
          min_x_next = cx;
          min_y_next = cy;
        end
      endcase
    end
  end

  // in_prod holds the area of the previous level
  always_comb begin
    ctrl_next = in_ctrl;
    if (DO_CMP && (in_ctrl.opcode == OP_LEVELS) && !in_ctrl.found &&
        (CMPW'(in_prod) <= CMPW'(in_limit))) begin
      ctrl_next.found = 1'b1;
      ctrl_next.lvl   = 4'(CMP_LEVEL);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_ctrl  <= ctrl_next;
      out_min_x <= min_x_next;
      out_min_y <= min_y_next;
      out_max_x <= max_x_next;
      out_max_y <= max_y_next;
      out_x     <= in_x;
      out_y     <= in_y;
      out_code  <= code_next;
      out_limit <= in_limit;
      out_w     <= in_w >> 1;
      out_h     <= in_h >> 1;
      out_prod  <= PW'(in_w) * PW'(in_h);
    end
  end

endmodule

// ----- tb/quadtree_tile_id_codec_unit_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// quadtree_tile_id_codec_unit_tb
// Self-checking bench for the quadtree tile id codec. Items go in on the
// slave stream, and each result is compared field by field with a prediction
// made when its item was accepted. A short directed run on the reset box
// comes first. Random runs follow over normal, tiny, degenerate and inverted
// root boxes, with random idling on both sides of the stream outside the calm run.
// ----------------------------------------------------------------------------
module quadtree_tile_id_codec_unit_tb;
  import qtc_pkg::*;

  localparam int         MAX_LEVELS = 12;
  localparam logic [1:0] OP_UNUSED  = 2'd3;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] loc_x;
    logic [15:0] loc_y;
    logic [3:0]  depth_req;
    logic [31:0] tile_id;
    logic [31:0] max_size;
  } tile_req_t;

  typedef struct packed {
    logic [31:0] result_id;
    logic [15:0] min_x;
    logic [15:0] min_y;
    logic [15:0] max_x;
    logic [15:0] max_y;
    logic [3:0]  levels;
    logic        ok;
  } tile_res_t;

  typedef struct packed {
    logic [15:0] min_x;
    logic [15:0] min_y;
    logic [15:0] max_x;
    logic [15:0] max_y;
  } tile_box_t;

  // Predicts each tile result from its own copy of the root box and holds the
  // predictions in order until the matching result comes out.
  class tile_checker;
    tile_res_t   expected_tiles[$];
    logic [15:0] root_reg[4];
    int          errors;

    function new();
      root_reg[REG_MIN_X] = 16'h0000;
      root_reg[REG_MIN_Y] = 16'h0000;
      root_reg[REG_MAX_X] = 16'hFFFF;
      root_reg[REG_MAX_Y] = 16'hFFFF;
      errors = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [15:0] val);
      root_reg[idx] = val;
    endfunction

    // Span wraps at 17 bits, so an inverted box still gives a value
    function logic [16:0] axis_span(logic [15:0] lo, logic [15:0] hi);
      return {1'b0, hi} - {1'b0, lo} + 17'd1;
    endfunction

    function logic [15:0] axis_centre(logic [15:0] lo, logic [15:0] hi);
      logic [16:0] s;
      s = axis_span(lo, hi);
      return lo + s[16:1];
    endfunction

    function tile_box_t split_box(tile_box_t b, logic [1:0] quad,
                                  logic [15:0] cx, logic [15:0] cy);
      case (quad)
        QUAD_RT: begin
          b.min_x = cx;
          b.max_y = cy;
        end
        QUAD_LT: begin
          b.max_x = cx;
          b.max_y = cy;
        end
        QUAD_LB: begin
          b.max_x = cx;
          b.min_y = cy;
        end
        default: begin
          b.min_x = cx;
          b.min_y = cy;
        end
      endcase
      return b;
    endfunction

    function tile_res_t tile_outcome(tile_req_t r);
      tile_res_t   res;
      tile_box_t   b;
      logic [15:0] cx;
      logic [15:0] cy;
      logic [1:0]  quad;
      logic [27:0] rest;
      logic [16:0] w;
      logic [16:0] h;
      logic        hit;
      res = '0;
      b.min_x = root_reg[REG_MIN_X];
      b.min_y = root_reg[REG_MIN_Y];
      b.max_x = root_reg[REG_MAX_X];
      b.max_y = root_reg[REG_MAX_Y];
      case (r.opcode)
        OP_ENCODE: if (r.depth_req <= MAX_LEVELS) begin
          res.result_id[3:0] = r.depth_req;
          for (int k = 0; k < r.depth_req; k++) begin
            cx = axis_centre(b.min_x, b.max_x);
            cy = axis_centre(b.min_y, b.max_y);
            if (r.loc_y <= cy) quad = (r.loc_x >= cx) ? QUAD_RT : QUAD_LT;
            else quad = (r.loc_x < cx) ? QUAD_LB : QUAD_RB;
            res.result_id[4 + 2*k +: 2] = quad;
            b = split_box(b, quad, cx, cy);
          end
          res.ok = 1'b1;
        end
        OP_DECODE: begin
          // Levels past the fourteenth read zero pairs once rest runs dry
          rest = r.tile_id[31:4];
          for (int k = 0; k < r.tile_id[3:0]; k++) begin
            cx = axis_centre(b.min_x, b.max_x);
            cy = axis_centre(b.min_y, b.max_y);
            b = split_box(b, rest[1:0], cx, cy);
            rest = rest >> 2;
          end
          res.min_x  = b.min_x;
          res.min_y  = b.min_y;
          res.max_x  = b.max_x;
          res.max_y  = b.max_y;
          res.levels = r.tile_id[3:0];
          res.ok     = (rest == '0);
        end
        OP_LEVELS: begin
          w = axis_span(b.min_x, b.max_x);
          h = axis_span(b.min_y, b.max_y);
          res.levels = LEVELS_NONE;
          hit = 1'b0;
          for (int k = 0; k <= MAX_LEVELS; k++) begin
            // Exact area, no wrap at 32 bits
            if (!hit && 64'(w) * 64'(h) <= 64'(r.max_size)) begin
              res.levels = 4'(k);
              res.ok     = 1'b1;
              hit        = 1'b1;
            end
            w = w >> 1;
            h = h >> 1;
          end
        end
        default: ;
      endcase
      return res;
    endfunction

    function void note_item(tile_req_t r);
      expected_tiles.push_back(tile_outcome(r));
    endfunction

    function int pending();
      return expected_tiles.size();
    endfunction

    function void fail(string msg);
      errors++;
      if (errors <= 10) $display("%0t ns: mismatch: %s", $time, msg);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) fail($sformatf("%s expected %0h actual %0h", name, want, got));
    endfunction

    function void check_tile(logic [103:0] d, logic ok);
      tile_res_t want;
      if (expected_tiles.size() == 0) begin
        fail("result with no item outstanding");
        return;
      end
      want = expected_tiles.pop_front();
      compare_field("result_id",  want.result_id, d[31:0]);
      compare_field("out_min_x",  want.min_x,     d[47:32]);
      compare_field("out_min_y",  want.min_y,     d[63:48]);
      compare_field("out_max_x",  want.max_x,     d[79:64]);
      compare_field("out_max_y",  want.max_y,     d[95:80]);
      compare_field("levels_out", want.levels,    d[99:96]);
      compare_field("ok",         want.ok,        ok);
    endfunction
  endclass

  logic          clk       = 1'b0;
  logic          rst       = 1'b1;
  logic          cfg_wr_en = 1'b0;
  logic [1:0]    cfg_index = REG_MIN_X;
  logic [15:0]   cfg_wdata = '0;
  logic          s_tvalid  = 1'b0;
  logic          s_tready;
  logic [103:0]  s_tdata   = '0;   // loc_x, loc_y, depth_req, tile_id, max_size, fill
  logic [1:0]    s_tuser   = OP_ENCODE;   // opcode
  logic          m_tvalid;
  logic          m_tready  = 1'b0;
  logic [103:0]  m_tdata;          // result_id, min/max x/y, levels_out, fill
  logic          m_tuser;          // ok
  logic          calm      = 1'b0; // high: no idling on either side

  tile_checker board;

  quadtree_tile_id_codec_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Stall the master side at random, with a chance of about 8 in 100, unless calm
  always @(negedge clk) begin
    m_tready <= calm || ($urandom_range(99) >= 8);
  end

  // Check every result item as it is taken
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) board.check_tile(m_tdata, m_tuser);
  end

  // Offer one item, idling first at random; return on the falling edge after
  // acceptance with tvalid still high, so back-to-back items need no drop.
  task automatic send_req(tile_req_t r);
    while (!calm && $urandom_range(99) < 8) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= r.opcode;
    s_tdata  <= {4'b0, r.max_size, r.tile_id, r.depth_req, r.loc_y, r.loc_x};
    do @(posedge clk); while (!s_tready);
    board.note_item(r);
    @(negedge clk);
  endtask

  // Hold off the sender until every outstanding result has come back
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (board.pending() != 0);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    board.set_reg(idx, val);
    @(negedge clk);
  endtask

  task automatic set_box(logic [15:0] mnx, logic [15:0] mny,
                         logic [15:0] mxx, logic [15:0] mxy);
    write_reg(REG_MIN_X, mnx);
    write_reg(REG_MIN_Y, mny);
    write_reg(REG_MAX_X, mxx);
    write_reg(REG_MAX_Y, mxy);
    cfg_wr_en <= 1'b0;
  endtask

  // All fields random; the opcode decides which ones matter
  function automatic tile_req_t noise_req(logic [1:0] op);
    tile_req_t r;
    r.opcode    = op;
    r.loc_x     = 16'($urandom);
    r.loc_y     = 16'($urandom);
    r.depth_req = 4'($urandom);
    r.tile_id   = $urandom;
    r.max_size  = $urandom;
    return r;
  endfunction

  function automatic tile_req_t random_req();
    tile_req_t   r;
    logic [15:0] lo_x;
    logic [15:0] lo_y;
    logic [15:0] hi_x;
    logic [15:0] hi_y;
    logic [63:0] area;
    int          pick;
    int          lv;
    pick = $urandom_range(99);
    r = noise_req(pick < 35 ? OP_ENCODE : pick < 70 ? OP_DECODE :
                  pick < 95 ? OP_LEVELS : OP_UNUSED);
    lo_x = board.root_reg[REG_MIN_X];
    lo_y = board.root_reg[REG_MIN_Y];
    hi_x = board.root_reg[REG_MAX_X];
    hi_y = board.root_reg[REG_MAX_Y];
    case (r.opcode)
      OP_ENCODE: begin
        r.depth_req = ($urandom_range(9) == 0) ? 4'($urandom_range(15, MAX_LEVELS + 1))
                                                : 4'($urandom_range(MAX_LEVELS));
        // Aim mostly inside a well-formed box
        if ($urandom_range(4) != 0 && hi_x >= lo_x && hi_y >= lo_y) begin
          r.loc_x = lo_x + 16'($urandom_range(hi_x - lo_x));
          r.loc_y = lo_y + 16'($urandom_range(hi_y - lo_y));
        end
      end
      OP_DECODE: if ($urandom_range(6) != 0) begin
        // Well-formed id: clear every bit above the used pairs
        lv = $urandom_range(14);
        if (lv < 14) r.tile_id = r.tile_id & ((32'd1 << (4 + 2*lv)) - 32'd1);
        r.tile_id[3:0] = 4'(lv);
      end
      OP_LEVELS: begin
        pick = $urandom_range(2);
        if (pick == 0) begin
          r.max_size = r.max_size >> $urandom_range(31);
        end else if (pick == 1) begin
          // Land just around the area of some level
          lv = $urandom_range(MAX_LEVELS);
          area = (64'(board.axis_span(lo_x, hi_x)) >> lv) *
                 (64'(board.axis_span(lo_y, hi_y)) >> lv);
          area = area + $urandom_range(2) - 1;
          r.max_size = (area > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : area[31:0];
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic send_enc(logic [15:0] x, logic [15:0] y, logic [3:0] depth);
    tile_req_t r;
    r = noise_req(OP_ENCODE);
    r.loc_x     = x;
    r.loc_y     = y;
    r.depth_req = depth;
    send_req(r);
  endtask

  task automatic send_dec(logic [31:0] id);
    tile_req_t r;
    r = noise_req(OP_DECODE);
    r.tile_id = id;
    send_req(r);
  endtask

  task automatic send_lvl(logic [31:0] limit);
    tile_req_t r;
    r = noise_req(OP_LEVELS);
    r.max_size = limit;
    send_req(r);
  endtask

  task automatic run_phase(logic [15:0] mnx, logic [15:0] mny,
                           logic [15:0] mxx, logic [15:0] mxy, int count);
    drain();
    set_box(mnx, mny, mxx, mxy);
    repeat (count) send_req(random_req());
  endtask

  initial begin
    tile_req_t r;
    board = new();
    repeat (9) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // Directed items on the reset box, 0..65535 on both axes
    send_enc(16'h0000, 16'h0000, 4'd0);
    send_enc(16'hFFFF, 16'hFFFF, 4'd12);
    send_enc(16'h0000, 16'hFFFF, 4'd12);
    send_enc(16'hFFFF, 16'h0000, 4'd5);
    send_enc(16'h8000, 16'h7FFF, 4'd12);    // on the centre column, just above the centre row
    send_enc(16'h1234, 16'h4321, 4'd13);    // too deep
    send_enc(16'hFFFF, 16'hFFFF, 4'd15);    // too deep
    send_dec(32'h0000_0000);
    send_dec(32'h0FFF_FFFC);                // twelve levels, all bottom right
    send_dec(32'h1FFF_FFFC);                // leftover bit above the pairs
    send_dec(32'hFFFF_FFFE);                // fourteen levels, id full
    send_dec(32'hFFFF_FFFF);                // level count past the id
    send_dec(32'h0000_000F);
    send_dec(32'h1234_5673);
    send_lvl(32'h0000_0000);                // nothing fits
    send_lvl(32'hFFFF_FFFF);                // root area just over 32 bits
    send_lvl(32'h4000_0000);
    send_lvl(32'h3FFF_FFFF);
    send_lvl(32'h0000_0100);                // fits at the deepest level
    send_lvl(32'h0000_00FF);
    send_req(noise_req(OP_UNUSED));
    r = '1;
    send_req(r);                            // unused opcode, every bit set

    // Full box written explicitly; pause midway until all results are in
    run_phase(16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 150);
    drain();
    repeat (150) send_req(random_req());

    // Small box with no idling on either side
    calm <= 1'b1;
    run_phase(16'd100, 16'd200, 16'd163, 16'd215, 300);
    calm <= 1'b0;

    run_phase(16'd7, 16'd7, 16'd7, 16'd7, 150);              // single pixel
    run_phase(16'd1000, 16'd2000, 16'd1001, 16'd2001, 100);  // two by two
    run_phase(16'd60000, 16'd50000, 16'd1000, 16'd2000, 200); // inverted
    run_phase(16'h0000, 16'h0000, 16'h0000, 16'h0000, 100);
    run_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 100);
    run_phase(16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000, 100);  // y inverted
    repeat (4) begin
      run_phase(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 150);
    end

    // Let any stray result show up before the verdict
    drain();
    repeat (24) @(negedge clk);
    if (board.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
